FILE: rtl/des_block_cipher_core_macros.svh
// Assertion macros shared by the DES core checkers
`ifndef DES_BLOCK_CIPHER_CORE_MACROS_SVH
`define DES_BLOCK_CIPHER_CORE_MACROS_SVH

// Implication checked on the same edge, off while reset is held
`define DES_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked on the following edge, off while reset is held
`define DES_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Implication checked on the following edge, also active through reset
`define DES_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/des_pkg.sv
// DES tables, stage types and bit permutation functions
`timescale 1ns / 1ps

package des_pkg;

    localparam int NUM_ROUNDS = 16;

    typedef struct packed {
        logic        decrypt;
        logic [31:0] left;
        logic [31:0] right;
    } des_blk_t;

    localparam logic [6:0] IP_TAB [64] = '{
        7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
        7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
        7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
        7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
        7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
        7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
    };

    localparam logic [6:0] FP_TAB [64] = '{
        7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
        7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
        7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
        7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
        7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
        7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
        7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
        7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
    };

    localparam logic [5:0] E_TAB [48] = '{
        6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,
        6'd6,  6'd7,  6'd8,  6'd9,  6'd8,  6'd9,  6'd10, 6'd11,
        6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
        6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21,
        6'd22, 6'd23, 6'd24, 6'd25, 6'd24, 6'd25, 6'd26, 6'd27,
        6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
    };

    localparam logic [5:0] P_TAB [32] = '{
        6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
        6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
        6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
        6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
    };

    localparam logic [6:0] PC1_TAB [56] = '{
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
        7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
        7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
        7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55, 7'd47, 7'd39,
        7'd31, 7'd23, 7'd15, 7'd7,  7'd62, 7'd54, 7'd46, 7'd38,
        7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37,
        7'd29, 7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
    };

    localparam logic [6:0] PC2_TAB [48] = '{
        7'd14, 7'd17, 7'd11, 7'd24, 7'd1,  7'd5,  7'd3,  7'd28,
        7'd15, 7'd6,  7'd21, 7'd10, 7'd23, 7'd19, 7'd12, 7'd4,
        7'd26, 7'd8,  7'd16, 7'd7,  7'd27, 7'd20, 7'd13, 7'd2,
        7'd41, 7'd52, 7'd31, 7'd37, 7'd47, 7'd55, 7'd30, 7'd40,
        7'd51, 7'd45, 7'd33, 7'd48, 7'd44, 7'd49, 7'd39, 7'd56,
        7'd34, 7'd53, 7'd46, 7'd42, 7'd50, 7'd36, 7'd29, 7'd32
    };

    localparam logic [1:0] ROT_TAB [16] = '{
        2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
        2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1
    };

    localparam logic [3:0] SBOX [8][64] = '{
        '{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
          4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7,
          4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
          4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8,
          4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
          4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0,
          4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
          4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13},
        '{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
          4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10,
          4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
          4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5,
          4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
          4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15,
          4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
          4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9},
        '{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
          4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8,
          4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
          4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
          4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
          4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7,
          4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
          4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12},
        '{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
          4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15,
          4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
          4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9,
          4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
          4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4,
          4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
          4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14},
        '{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
          4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9,
          4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
          4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6,
          4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
          4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14,
          4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
          4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3},
        '{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
          4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11,
          4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
          4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8,
          4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
          4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6,
          4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
          4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13},
        '{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
          4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1,
          4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
          4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6,
          4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
          4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2,
          4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
          4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12},
        '{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
          4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7,
          4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
          4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2,
          4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
          4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8,
          4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
          4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}
    };

    // Total left rotation of the key halves up to and including round idx
    function automatic int rot_total(input int idx);
        int sum;
        sum = 0;
        for (int k = 0; k <= idx; k++) begin
            sum = sum + int'(ROT_TAB[k % 16]);
        end
        return sum;
    endfunction

    function automatic logic [63:0] ip_perm(input logic [63:0] x);
        logic [63:0] y;
        for (int i = 0; i < 64; i++) begin
            y[63 - i] = x[6'(7'd64 - IP_TAB[i])];
        end
        return y;
    endfunction

    function automatic logic [63:0] fp_perm(input logic [63:0] x);
        logic [63:0] y;
        for (int i = 0; i < 64; i++) begin
            y[63 - i] = x[6'(7'd64 - FP_TAB[i])];
        end
        return y;
    endfunction

    function automatic logic [47:0] e_expand(input logic [31:0] x);
        logic [47:0] y;
        for (int i = 0; i < 48; i++) begin
            y[47 - i] = x[5'(6'd32 - E_TAB[i])];
        end
        return y;
    endfunction

    function automatic logic [31:0] p_perm(input logic [31:0] x);
        logic [31:0] y;
        for (int i = 0; i < 32; i++) begin
            y[31 - i] = x[5'(6'd32 - P_TAB[i])];
        end
        return y;
    endfunction

    function automatic logic [55:0] pc1_perm(input logic [63:0] x);
        logic [55:0] y;
        for (int i = 0; i < 56; i++) begin
            y[55 - i] = x[6'(7'd64 - PC1_TAB[i])];
        end
        return y;
    endfunction

    function automatic logic [47:0] pc2_perm(input logic [55:0] x);
        logic [47:0] y;
        for (int i = 0; i < 48; i++) begin
            y[47 - i] = x[6'(7'd56 - PC2_TAB[i])];
        end
        return y;
    endfunction

    // Round function: expand, mix in the round key, substitute, permute
    function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
        logic [47:0] e;
        logic [5:0]  six;
        logic [31:0] s;
        e = e_expand(r) ^ k;
        s = '0;
        for (int i = 0; i < 8; i++) begin
            six = e[47 - 6 * i -: 6];
            s[31 - 4 * i -: 4] = SBOX[i][{six[5], six[0], six[4:1]}];
        end
        return p_perm(s);
    endfunction

endpackage

FILE: rtl/des_block_cipher_core.sv
// DES block cipher core: key schedule and a chain of sixteen round cells
//
// Usage:
//   Key:    write the 64-bit key on cfg_cipher_key with cfg_valid; cfg_ready is
//           always high. Write it only while no request is in flight. Parity
//           bits of the key are ignored.
//   Input:  s_valid/s_ready carry one 64-bit block (s_data_in) and s_operation
//           (0 encrypt, 1 decrypt). One request is taken per cycle while s_ready is high.
//   Output: m_valid/m_ready carry the 64-bit result block on m_data_out, in
//           request order.
//   Flow:   each block moves through the round cells one cell per cycle when
//           not stalled, and m_valid rises once it is in the last cell; the
//           chain takes new blocks before earlier ones are through.
//   Stall:  each cell advances when it is empty or its neighbor advances, so
//           when m_ready is low the results back up cell by cell and empty
//           cells keep taking requests; s_ready drops only once the chain is
//           full.
//   Reset:  aresetn (synchronous, active low) clears the key to zero and
//           empties every cell.
`timescale 1ns / 1ps

module des_block_cipher_core
    import des_pkg::*;
#(
    parameter int ROUND_COUNT = NUM_ROUNDS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_cipher_key,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [63:0] s_data_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_data_out
);

    logic [47:0] round_keys [ROUND_COUNT];
    logic        chain_valid [ROUND_COUNT + 1];
    logic        chain_ready [ROUND_COUNT + 1];
    des_blk_t    chain_blk   [ROUND_COUNT + 1];
    logic [63:0] ip_block;

    des_key_sched #(
        .ROUND_COUNT(ROUND_COUNT)
    ) u_key_sched (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_cipher_key(cfg_cipher_key),
        .round_keys    (round_keys)
    );

    assign ip_block             = ip_perm(s_data_in);
    assign chain_valid[0]       = s_valid;
    assign chain_blk[0].decrypt = s_operation;
    assign chain_blk[0].left    = ip_block[63:32];
    assign chain_blk[0].right   = ip_block[31:0];
    assign s_ready              = chain_ready[0];

    for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_cell
        des_round_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .up_valid(chain_valid[i]),
            .up_ready(chain_ready[i]),
            .up_blk  (chain_blk[i]),
            .key_enc (round_keys[i]),
            .key_dec (round_keys[ROUND_COUNT - 1 - i]),
            .dn_valid(chain_valid[i + 1]),
            .dn_ready(chain_ready[i + 1]),
            .dn_blk  (chain_blk[i + 1])
        );
    end

    // Last cell is the output register; swap halves and undo IP on the way out
    assign chain_ready[ROUND_COUNT] = m_ready;
    assign m_valid    = chain_valid[ROUND_COUNT];
    assign m_data_out = fp_perm({chain_blk[ROUND_COUNT].right, chain_blk[ROUND_COUNT].left});

endmodule

FILE: rtl/des_key_sched.sv
// DES key register and round key schedule
`timescale 1ns / 1ps

module des_key_sched
    import des_pkg::*;
#(
    parameter int ROUND_COUNT = NUM_ROUNDS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_cipher_key,
    output logic [47:0] round_keys [ROUND_COUNT]
);

    logic [63:0] key_reg;
    logic [63:0] key_next;
    logic [55:0] cd_init;

    assign cfg_ready = 1'b1;
    assign key_next  = cfg_valid ? cfg_cipher_key : key_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else begin
            key_reg <= key_next;
        end
    end

    assign cd_init = pc1_perm(key_reg);

    // Each round key is a fixed rewiring of the key: rotate both halves by
    // the accumulated shift, then select through PC-2
    for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_round
        localparam int SH = rot_total(i) % 28;
        logic [27:0] c_rot;
        logic [27:0] d_rot;
        assign c_rot = (cd_init[55:28] << SH) | (cd_init[55:28] >> (28 - SH));
        assign d_rot = (cd_init[27:0] << SH) | (cd_init[27:0] >> (28 - SH));
        assign round_keys[i] = pc2_perm({c_rot, d_rot});
    end

endmodule

FILE: rtl/des_round_cell.sv
// One Feistel round stage with its own valid bit and local flow control
`timescale 1ns / 1ps

module des_round_cell
    import des_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        up_valid,
    output logic        up_ready,
    input  des_blk_t    up_blk,
    input  logic [47:0] key_enc,
    input  logic [47:0] key_dec,
    output logic        dn_valid,
    input  logic        dn_ready,
    output des_blk_t    dn_blk
);

    logic        valid_reg;
    logic        valid_next;
    des_blk_t    blk_reg;
    des_blk_t    blk_next;
    logic        advance;
    logic [47:0] key_sel;

    // Take a new request when empty or when the held one moves on
    assign advance    = !valid_reg || dn_ready;
    assign up_ready   = advance;
    assign valid_next = advance ? up_valid : valid_reg;
    assign key_sel    = up_blk.decrypt ? key_dec : key_enc;

    always_comb begin
        blk_next = blk_reg;
        if (advance && up_valid) begin
            blk_next.decrypt = up_blk.decrypt;
            blk_next.left    = up_blk.right;
            blk_next.right   = up_blk.left ^ feistel(up_blk.right, key_sel);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        blk_reg <= blk_next;
    end

    assign dn_valid = valid_reg;
    assign dn_blk   = blk_reg;

endmodule

FILE: rtl/des_chk.sv
// Port-level checker for the DES core, bound to the top level
`timescale 1ns / 1ps
`include "des_block_cipher_core_macros.svh"

module des_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [63:0] cfg_cipher_key,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_operation,
    input logic [63:0] s_data_in,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_data_out
);

    // A stalled result holds its value
    `DES_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data_out), "result changed while stalled")

    // Reset empties the chain
    `DES_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid, "result valid after reset")

    // With the output free, every cell can move, so the input is never blocked
    `DES_ASSERT_NOW(a_in_free, aclk, aresetn, !m_valid || m_ready, s_ready, "input blocked while output free")

    // Key writes are never refused
    `DES_ASSERT_NOW(a_cfg_ready, aclk, aresetn, cfg_valid, cfg_ready, "key write refused")

endmodule

bind des_block_cipher_core des_chk u_des_chk (.*);

FILE: dv/tb_top.sv
// Self-checking testbench for the DES block cipher core: key writes, encrypt and decrypt requests
`timescale 1ns / 1ps

module tb_top;

    localparam int ROUNDS           = 16;
    localparam int LATENCY          = 16;
    localparam int STUCK_LIMIT      = 2000;
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int RANDOM_PHASES    = 9;
    localparam int BLOCKS_PER_PHASE = 150;

    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } des_op_e;

    typedef enum int {
        SEL_IP,
        SEL_FP,
        SEL_E,
        SEL_P,
        SEL_PC1,
        SEL_PC2
    } bit_map_e;

    typedef struct {
        des_op_e     op;
        logic [63:0] data;
    } cipher_req_t;

    // Bit positions count from 1 at the most significant bit
    localparam int INIT_PERM [64] = '{
        58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7 };
    localparam int FINAL_PERM [64] = '{
        40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25 };
    localparam int EXPAND_SEL [48] = '{
        32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
        16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1 };
    localparam int ROUND_PERM [32] = '{
        16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25 };
    localparam int KEY_SEL1 [56] = '{
        57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
        60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,
        61,53,45,37,29,21,13,5,28,20,12,4 };
    localparam int KEY_SEL2 [48] = '{
        14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
        41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32 };
    localparam int KEY_SHIFT [16] = '{ 1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1 };
    localparam int SUBST [8][64] = '{
        '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
          4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
        '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
          0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
        '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
          13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
        '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
          10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
        '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
          4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
        '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
          9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
        '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
          1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
        '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
          7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11} };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [63:0] cfg_cipher_key = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_operation = 1'b0;
    logic [63:0] s_data_in = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_data_out;

    logic [47:0] round_key [ROUNDS];
    cipher_req_t pending_blocks [$];
    logic [63:0] results_due [$];
    int          blocks_submitted = 0;
    int          blocks_accepted = 0;
    int          mismatches = 0;
    int          stuck_cycles = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic        in_fire = 1'b0;
    bit          hold_armed = 1'b0;
    bit          hold_used = 1'b0;
    int          hold_left = 0;

    des_block_cipher_core i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_cipher_key (cfg_cipher_key),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_data_in      (s_data_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data_out     (m_data_out)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Pick count bits out of a width-bit word, MSB first
    function automatic logic [63:0] gather_bits(logic [63:0] src, int width, bit_map_e map,
                                                int count);
        logic [63:0] dst;
        int          pos;
        dst = '0;
        pos = 1;
        for (int i = 0; i < count; i++) begin
            case (map)
                SEL_IP:  pos = INIT_PERM[i];
                SEL_FP:  pos = FINAL_PERM[i];
                SEL_E:   pos = EXPAND_SEL[i];
                SEL_P:   pos = ROUND_PERM[i];
                SEL_PC1: pos = KEY_SEL1[i];
                SEL_PC2: pos = KEY_SEL2[i];
                default: pos = 1;
            endcase
            dst = {dst[62:0], src[width - pos]};
        end
        return dst;
    endfunction

    function automatic void load_key_schedule(logic [63:0] key);
        logic [63:0] cd;
        logic [27:0] c;
        logic [27:0] d;
        cd = gather_bits(key, 64, SEL_PC1, 56);
        c  = cd[55:28];
        d  = cd[27:0];
        for (int r = 0; r < ROUNDS; r++) begin
            for (int s = 0; s < KEY_SHIFT[r]; s++) begin
                c = {c[26:0], c[27]};
                d = {d[26:0], d[27]};
            end
            cd = gather_bits({8'h00, c, d}, 56, SEL_PC2, 48);
            round_key[r] = cd[47:0];
        end
    endfunction

    function automatic logic [31:0] mix_half(logic [31:0] r, logic [47:0] k);
        logic [63:0] w;
        logic [47:0] x;
        logic [5:0]  six;
        logic [31:0] s;
        int          row;
        int          col;
        w = gather_bits({32'h0, r}, 32, SEL_E, 48);
        x = w[47:0] ^ k;
        s = '0;
        for (int i = 0; i < 8; i++) begin
            six = x[47 - 6 * i -: 6];
            row = int'({six[5], six[0]});
            col = int'(six[4:1]);
            s   = {s[27:0], 4'(SUBST[i][row * 16 + col])};
        end
        w = gather_bits({32'h0, s}, 32, SEL_P, 32);
        return w[31:0];
    endfunction

    function automatic logic [63:0] des_expected(logic op, logic [63:0] blk);
        logic [63:0] w;
        logic [31:0] l;
        logic [31:0] r;
        logic [31:0] t;
        int          kidx;
        w = gather_bits(blk, 64, SEL_IP, 64);
        l = w[63:32];
        r = w[31:0];
        for (int i = 0; i < ROUNDS; i++) begin
            kidx = (op == OP_DECRYPT) ? ROUNDS - 1 - i : i;
            t = l ^ mix_half(r, round_key[kidx]);
            l = r;
            r = t;
        end
        return gather_bits({r, l}, 64, SEL_FP, 64);
    endfunction

    function automatic logic [63:0] random_block();
        logic [63:0] one_hot;
        one_hot = 64'h1 << $urandom_range(63);
        case ($urandom_range(7))
            0:       return one_hot;
            1:       return ~one_hot;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic queue_block(des_op_e op, logic [63:0] data);
        cipher_req_t req;
        req.op   = op;
        req.data = data;
        pending_blocks.push_back(req);
        blocks_submitted++;
    endtask

    task automatic wait_drain();
        do @(negedge aclk);
        while (blocks_accepted != blocks_submitted || results_due.size() != 0);
    endtask

    task automatic write_key(logic [63:0] key);
        @(negedge aclk);
        cfg_cipher_key <= key;
        cfg_valid      <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        load_key_schedule(key);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Request driver: hold the payload until it is taken
    always @(negedge aclk) begin
        cipher_req_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_fire) begin
            if (pending_blocks.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                req = pending_blocks.pop_front();
                s_operation <= req.op;
                s_data_in   <= req.data;
                s_valid     <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side: random back-pressure, plus one long hold to fill the rounds
    always @(negedge aclk) begin
        if (hold_armed && !hold_used) begin
            hold_used = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        logic [63:0] want;
        in_fire <= aresetn && s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            if (results_due.size() == 0) begin
                $error("data_out: no result expected, actual %h", m_data_out);
                mismatches++;
            end else begin
                want = results_due.pop_front();
                if (m_data_out !== want) begin
                    $error("data_out: expected %h, actual %h", want, m_data_out);
                    mismatches++;
                end
            end
        end
        if (aresetn && s_valid && s_ready) begin
            results_due.push_back(des_expected(s_operation, s_data_in));
            blocks_accepted++;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        des_op_e op;
        load_key_schedule('0);
        tx_idle_pct = 11;
        rx_idle_pct = 77;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset key (all zero) before any write
        queue_block(OP_ENCRYPT, 64'h0000_0000_0000_0000);
        queue_block(OP_ENCRYPT, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_block(OP_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_block(OP_DECRYPT, 64'h0000_0000_0000_0000);
        wait_drain();

        write_key(64'h1334_5779_9BBC_DFF1);
        queue_block(OP_ENCRYPT, 64'h0123_4567_89AB_CDEF);
        queue_block(OP_DECRYPT, 64'h85E8_1354_0F0A_B405);
        queue_block(OP_ENCRYPT, 64'hAAAA_AAAA_AAAA_AAAA);
        queue_block(OP_DECRYPT, 64'h5555_5555_5555_5555);
        wait_drain();

        write_key(64'hFFFF_FFFF_FFFF_FFFF);
        queue_block(OP_ENCRYPT, 64'h0000_0000_0000_0000);
        queue_block(OP_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFF);
        wait_drain();

        // Weak key: parity bits only, same schedule as the zero key
        write_key(64'h0101_0101_0101_0101);
        queue_block(OP_ENCRYPT, 64'h0123_4567_89AB_CDEF);
        queue_block(OP_DECRYPT, 64'h0123_4567_89AB_CDEF);
        wait_drain();

        // Semi-weak key
        write_key(64'h01FE_01FE_01FE_01FE);
        queue_block(OP_ENCRYPT, 64'h8000_0000_0000_0001);
        queue_block(OP_DECRYPT, 64'h7FFF_FFFF_FFFF_FFFE);
        wait_drain();

        write_key(64'h0000_0000_0000_0000);
        queue_block(OP_ENCRYPT, 64'hFEDC_BA98_7654_3210);
        queue_block(OP_DECRYPT, 64'h0000_0000_0000_0001);
        wait_drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            tx_idle_pct = (ph < 3) ? 11 : (ph < 6) ? 77 : 0;
            rx_idle_pct = (ph < 3) ? 77 : (ph < 6) ? 11 : 0;
            write_key({$urandom, $urandom});
            // Stall the result side while requests keep coming
            if (ph == 6) hold_armed = 1'b1;
            for (int n = 0; n < BLOCKS_PER_PHASE; n++) begin
                op = $urandom_range(1) ? OP_DECRYPT : OP_ENCRYPT;
                queue_block(op, random_block());
            end
            wait_drain();
        end

        repeat (3 * LATENCY) @(posedge aclk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
